FILE: rtl/core/rpsl_pkg.sv
package rpsl_pkg;

    // Fixed field widths of the sample, time, scale, window length, level and configuration fields.
    localparam int SAMPLE_BITS = 12;
    localparam int TIME_BITS   = 32;
    localparam int SCALE_BITS  = 13;
    localparam int WLEN_BITS   = 16;
    localparam int LEVEL_BITS  = 8;
    localparam int CFG_BITS    = 16;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [SCALE_BITS-1:0] FS_DIRECT_RST = SCALE_BITS'(2400);
    localparam logic [SCALE_BITS-1:0] FS_STREAM_RST = SCALE_BITS'(4610);
    localparam logic [WLEN_BITS-1:0]  WLEN_RST      = WLEN_BITS'(3000);
    localparam logic [LEVEL_BITS-1:0] LEVEL_MAX     = LEVEL_BITS'(255);

    typedef enum logic [1:0] {
        ACT_SAMPLE = 2'd0,
        ACT_READ   = 2'd1,
        ACT_REOPEN = 2'd2
    } t_action;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_STREAM_MODE = 2'd0,
        CFG_FS_DIRECT   = 2'd1,
        CFG_FS_STREAM   = 2'd2,
        CFG_WIN_LEN     = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [1:0]             action;
        logic [SAMPLE_BITS-1:0] sample;
        logic [TIME_BITS-1:0]   now_ms;
        logic                   tuning;
        logic                   powered_down;
    } t_in_item;

    typedef struct packed {
        logic [LEVEL_BITS-1:0]  rssi_level;
        logic [SAMPLE_BITS-1:0] raw_used;
        logic                   check_done;
        logic                   input_flat;
    } t_out_item;

endpackage

FILE: rtl/core/rssi_peak_scale_liveness.sv
// RSSI conditioner: running peak hold, scaling to 0..255 and a one-shot
// liveness check.
//
// Input channel (i_valid / o_ready, payload i_data) carries one item per
// handshake: a streamed sample, a read request or a window reopen. Only a
// read request produces an item on the output channel (o_valid / i_ready,
// payload o_data). The configuration port (i_cfg_we, i_cfg_index,
// i_cfg_data) writes one register per cycle and must only be used while
// the block is idle.
//
// Sample, reopen and unused items are absorbed in the cycle they are
// accepted, so such items stream at one per cycle while no read is in flight.
// A read that needs a division passes a step that forms raw*255, eight
// divider steps (one quotient bit each) and a step that loads the result. A
// tuning read or a read whose raw count reaches the full scale skips the
// divider and goes straight to the load. The input is not ready while a read
// is in flight, so no new item is taken until the read is loaded. A result
// waits in the output register until taken; meanwhile new items are accepted
// and a following read parks until the register is free. Synchronous
// active-low reset restores the defaults and clears peak, window and flags.
module rssi_peak_scale_liveness
    import rpsl_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  t_in_item                i_data,
    output logic                    o_valid,
    input  logic                    i_ready,
    output t_out_item               o_data,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [CFG_BITS-1:0]     i_cfg_data
);

    localparam int PROD_BITS = SAMPLE_BITS + LEVEL_BITS;
    localparam int CNT_BITS  = $clog2(LEVEL_BITS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_FIN
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic                   r_stream_mode;
    logic [SCALE_BITS-1:0]  r_fs_direct;
    logic [SCALE_BITS-1:0]  r_fs_stream;
    logic [WLEN_BITS-1:0]   r_win_len;

    // Block state.
    logic [SAMPLE_BITS-1:0] r_peak;
    logic [SAMPLE_BITS-1:0] r_held;
    logic [SAMPLE_BITS-1:0] r_last_raw;
    logic                   r_win_open;
    logic [TIME_BITS-1:0]   r_win_end;
    logic [SAMPLE_BITS-1:0] r_win_min;
    logic [SAMPLE_BITS-1:0] r_win_max;
    logic                   r_done;
    logic                   r_flat;

    // Divider working registers. The remainder always stays below the
    // divisor, and the dividend register fills with quotient bits as the
    // low dividend bits shift out.
    logic [SAMPLE_BITS-1:0] r_raw;
    logic [SCALE_BITS-1:0]  r_scale;
    logic [SCALE_BITS-1:0]  r_rem;
    logic [LEVEL_BITS-1:0]  r_dvd;
    logic [CNT_BITS-1:0]    r_cnt;
    logic [LEVEL_BITS-1:0]  r_level;

    logic                   r_out_valid;
    t_out_item              r_out;

    logic                   w_accept;
    logic                   w_out_free;
    logic [SAMPLE_BITS-1:0] w_raw;
    logic [SCALE_BITS-1:0]  w_scale;
    logic [SAMPLE_BITS-1:0] w_min;
    logic [SAMPLE_BITS-1:0] w_max;
    logic [PROD_BITS-1:0]   w_prod;
    logic [SCALE_BITS:0]    w_trial;
    logic [SCALE_BITS:0]    w_diff;
    logic                   w_qbit;

    assign o_ready    = (r_state == ST_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_out_valid || i_ready;
    assign o_valid    = r_out_valid;
    assign o_data     = r_out;

    // Raw count and full scale for a read. In stream mode an empty peak
    // repeats the last held stream value.
    always_comb begin
        if (r_stream_mode) begin
            w_raw   = (r_peak == '0) ? r_held : r_peak;
            w_scale = r_fs_stream;
        end else begin
            w_raw   = i_data.sample;
            w_scale = r_fs_direct;
        end
        w_min = (w_raw < r_win_min) ? w_raw : r_win_min;
        w_max = (w_raw > r_win_max) ? w_raw : r_win_max;
    end

    // raw * 255 as a shift and subtract.
    assign w_prod = {r_raw, {LEVEL_BITS{1'b0}}} - PROD_BITS'(r_raw);

    // One restoring division step.
    assign w_trial = {r_rem, r_dvd[LEVEL_BITS-1]};
    assign w_diff  = w_trial - {1'b0, r_scale};
    assign w_qbit  = !w_diff[SCALE_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_stream_mode <= 1'b0;
            r_fs_direct   <= FS_DIRECT_RST;
            r_fs_stream   <= FS_STREAM_RST;
            r_win_len     <= WLEN_RST;
            r_peak        <= '0;
            r_held        <= '0;
            r_last_raw    <= '0;
            r_win_open    <= 1'b0;
            r_win_end     <= '0;
            r_win_min     <= '1;
            r_win_max     <= '0;
            r_done        <= 1'b0;
            r_flat        <= 1'b0;
            r_cnt         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_STREAM_MODE: r_stream_mode <= i_cfg_data[0];
                    CFG_FS_DIRECT:   r_fs_direct   <= i_cfg_data[SCALE_BITS-1:0];
                    CFG_FS_STREAM:   r_fs_stream   <= i_cfg_data[SCALE_BITS-1:0];
                    CFG_WIN_LEN:     r_win_len     <= i_cfg_data[WLEN_BITS-1:0];
                    default: ;
                endcase
            end

            // In the final state the load below decides the output valid flag.
            if (r_out_valid && i_ready && (r_state != ST_FIN)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        case (t_action'(i_data.action))
                            ACT_SAMPLE: begin
                                if (r_stream_mode && (i_data.sample > r_peak)) begin
                                    r_peak <= i_data.sample;
                                end
                            end
                            ACT_REOPEN: begin
                                r_win_open <= 1'b0;
                                r_win_end  <= '0;
                                r_win_min  <= '1;
                                r_win_max  <= '0;
                                r_done     <= 1'b0;
                                r_flat     <= 1'b0;
                            end
                            ACT_READ: begin
                                if (i_data.tuning) begin
                                    r_level <= '0;
                                    r_state <= ST_FIN;
                                end else begin
                                    if (r_stream_mode) begin
                                        r_peak <= '0;
                                        if (r_peak != '0) begin
                                            r_held <= r_peak;
                                        end
                                    end
                                    r_last_raw <= w_raw;
                                    r_raw      <= w_raw;
                                    r_scale    <= w_scale;
                                    if (!r_done && !i_data.powered_down) begin
                                        if (!r_win_open) begin
                                            r_win_open <= 1'b1;
                                            r_win_end  <= i_data.now_ms
                                                          + TIME_BITS'(r_win_len);
                                            r_win_min  <= w_raw;
                                            r_win_max  <= w_raw;
                                        end else begin
                                            r_win_min <= w_min;
                                            r_win_max <= w_max;
                                            if (i_data.now_ms >= r_win_end) begin
                                                r_done <= 1'b1;
                                                r_flat <= (w_min == w_max);
                                            end
                                        end
                                    end
                                    if ({1'b0, w_raw} >= w_scale) begin
                                        r_level <= LEVEL_MAX;
                                        r_state <= ST_FIN;
                                    end else begin
                                        r_state <= ST_PREP;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_PREP: begin
                    r_rem   <= SCALE_BITS'(w_prod[PROD_BITS-1:LEVEL_BITS]);
                    r_dvd   <= w_prod[LEVEL_BITS-1:0];
                    r_cnt   <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_rem <= w_qbit ? w_diff[SCALE_BITS-1:0] : w_trial[SCALE_BITS-1:0];
                    r_dvd <= {r_dvd[LEVEL_BITS-2:0], w_qbit};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_BITS'(LEVEL_BITS - 1)) begin
                        r_level <= {r_dvd[LEVEL_BITS-2:0], w_qbit};
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (w_out_free) begin
                        r_out.rssi_level <= r_level;
                        r_out.raw_used   <= r_last_raw;
                        r_out.check_done <= r_done;
                        r_out.input_flat <= r_flat;
                        r_out_valid      <= 1'b1;
                        r_state          <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/core/rpsl_checker.sv
module rpsl_checker
    import rpsl_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_ready,
    input t_in_item  i_data,
    input logic      o_valid,
    input logic      i_ready,
    input t_out_item o_data
);

    // A result waiting at the output holds until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_data)))
        else $error("output item changed or dropped while stalled");

    // A flat verdict is only reported once the window has closed.
    a_flat_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.check_done) |-> !o_data.input_flat)
        else $error("flat verdict without a closed window");

    // A read occupies the block for at least the next cycle.
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_data.action == ACT_READ)) |=> !o_ready)
        else $error("ready right after accepting a read");

    // Other items are absorbed at once.
    a_other_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_data.action != ACT_READ)) |=> o_ready)
        else $error("not ready after a non-read item");

endmodule

bind rssi_peak_scale_liveness rpsl_checker u_rpsl_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

// Bench for the RSSI conditioner. The initial block runs a few directed tests
// and then random phases under several register settings. Every accepted input
// item is run through a behavioral copy of the block kept here. Every read
// request pushes the report that it should produce, and a separate process
// compares each report the block hands over with the oldest one waiting.
module tb_top;
    import rpsl_pkg::*;

    // Action code 3 has no meaning; the block must swallow it without a report.
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    // Drain wait after the last report before a register write; it outlasts a
    // divided read with some margin.
    localparam int DRAIN_CYCLES = 16;
    // Cycles with no handshake on either channel before the run is declared hung.
    localparam int HANG_LIMIT = 5000;
    localparam int PHASE_ITEMS = 200;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_item  i_data = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_item o_data;
    logic      i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = CFG_STREAM_MODE;
    logic [CFG_BITS-1:0]     i_cfg_data = '0;

    rssi_peak_scale_liveness dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the registers and of the conditioner state.
    logic                   m_stream;
    logic [SCALE_BITS-1:0]  m_fs_direct;
    logic [SCALE_BITS-1:0]  m_fs_stream;
    logic [WLEN_BITS-1:0]   m_win_len;
    logic [SAMPLE_BITS-1:0] m_peak;
    logic [SAMPLE_BITS-1:0] m_held;
    logic [SAMPLE_BITS-1:0] m_last_raw;
    logic                   m_open;
    logic [TIME_BITS-1:0]   m_end;
    logic [SAMPLE_BITS-1:0] m_min;
    logic [SAMPLE_BITS-1:0] m_max;
    logic                   m_done;
    logic                   m_flat;

    // Reports still owed by the block, oldest first.
    t_out_item reports_due[$];
    int unsigned errors = 0;

    // Stimulus state: a wall clock in ms that reads mostly step forward, and a
    // steady level used for whole windows so that flat verdicts do occur.
    logic [TIME_BITS-1:0]   wall_ms = '0;
    bit                     steady = 1'b0;
    logic [SAMPLE_BITS-1:0] steady_val = '0;

    task automatic clear_window();
        m_open = 1'b0;
        m_end  = '0;
        m_min  = '1;
        m_max  = '0;
        m_done = 1'b0;
        m_flat = 1'b0;
    endtask

    task automatic reset_model();
        m_stream    = 1'b0;
        m_fs_direct = FS_DIRECT_RST;
        m_fs_stream = FS_STREAM_RST;
        m_win_len   = WLEN_RST;
        m_peak      = '0;
        m_held      = '0;
        m_last_raw  = '0;
        clear_window();
    endtask

    // A read that opens the window only records its level; later reads widen
    // min and max and close the window once the time reaches the end mark.
    // The end mark wraps and is compared without any wrap handling.
    task automatic update_window(input logic [SAMPLE_BITS-1:0] raw,
                                 input logic [TIME_BITS-1:0] now);
        if (!m_open) begin
            m_open = 1'b1;
            m_end  = now + TIME_BITS'(m_win_len);
            m_min  = raw;
            m_max  = raw;
        end else begin
            if (raw < m_min) m_min = raw;
            if (raw > m_max) m_max = raw;
            if (now >= m_end) begin
                m_done = 1'b1;
                m_flat = (m_min == m_max);
            end
        end
    endtask

    // Applies one accepted item to the shadow state and queues the report
    // that a read request must produce.
    task automatic track_item(input t_in_item it);
        logic [SAMPLE_BITS-1:0] raw;
        logic [SCALE_BITS-1:0]  scale;
        int unsigned            quot;
        t_out_item              rep;
        case (it.action)
            ACT_SAMPLE: begin
                if (m_stream && it.sample > m_peak) m_peak = it.sample;
            end
            ACT_REOPEN: begin
                clear_window();
            end
            ACT_READ: begin
                rep.rssi_level = '0;
                // A tuning read reports level zero and leaves all state alone.
                if (!it.tuning) begin
                    if (m_stream) begin
                        raw = m_peak;
                        m_peak = '0;
                        if (raw == '0) raw = m_held;
                        else m_held = raw;
                        scale = m_fs_stream;
                    end else begin
                        raw = it.sample;
                        scale = m_fs_direct;
                    end
                    m_last_raw = raw;
                    // Saturation also covers a zero full scale.
                    if ({1'b0, raw} >= scale) begin
                        rep.rssi_level = LEVEL_MAX;
                    end else begin
                        quot = (32'(raw) * 32'd255) / 32'(scale);
                        rep.rssi_level = quot[LEVEL_BITS-1:0];
                    end
                    if (!m_done && !it.powered_down) update_window(raw, it.now_ms);
                end
                rep.raw_used   = m_last_raw;
                rep.check_done = m_done;
                rep.input_flat = m_flat;
                reports_due.push_back(rep);
            end
            default: begin
            end
        endcase
    endtask

    function automatic t_in_item make_item(input logic [1:0] act,
                                           input logic [SAMPLE_BITS-1:0] smp,
                                           input logic [TIME_BITS-1:0] now,
                                           input bit tune = 1'b0,
                                           input bit pdn = 1'b0);
        t_in_item it;
        it.action       = act;
        it.sample       = smp;
        it.now_ms       = now;
        it.tuning       = tune;
        it.powered_down = pdn;
        return it;
    endfunction

    // Presents one item and holds it until the block takes it. Valid is left
    // high so that the next item can follow in the very next cycle.
    task automatic send_item(input t_in_item it);
        i_valid <= 1'b1;
        i_data  <= it;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        track_item(it);
    endtask

    task automatic pause_sender(input int unsigned cycles);
        if (cycles != 0) begin
            i_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic wait_reports();
        i_valid <= 1'b0;
        while (reports_due.size() != 0) @(posedge i_clk);
    endtask

    // Items that produce no report may still be in flight after the last
    // report, so a register write first waits out the drain time as well.
    task automatic settle();
        wait_reports();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_BITS-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        case (idx)
            CFG_STREAM_MODE: m_stream    = value[0];
            CFG_FS_DIRECT:   m_fs_direct = value[SCALE_BITS-1:0];
            CFG_FS_STREAM:   m_fs_stream = value[SCALE_BITS-1:0];
            CFG_WIN_LEN:     m_win_len   = value[WLEN_BITS-1:0];
            default: begin
            end
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Writes every register; the unused upper bits carry junk that the block
    // must mask off.
    task automatic set_registers(input bit stream, input logic [SCALE_BITS-1:0] fsd,
                                 input logic [SCALE_BITS-1:0] fss,
                                 input logic [WLEN_BITS-1:0] wlen);
        settle();
        write_reg(CFG_STREAM_MODE, {15'($urandom()), stream});
        write_reg(CFG_FS_DIRECT, {3'($urandom()), fsd});
        write_reg(CFG_FS_STREAM, {3'($urandom()), fss});
        write_reg(CFG_WIN_LEN, wlen);
    endtask

    // Direct mode with the reset registers: scaling edges, a tuning read, a
    // powered-down read, ignored items, and both kinds of verdict.
    task automatic test_direct_reads();
        send_item(make_item(ACT_READ, 12'd0, 32'd100));
        send_item(make_item(ACT_READ, 12'd4095, 32'd200, 1'b1));
        send_item(make_item(ACT_READ, 12'd2399, 32'd300));
        send_item(make_item(ACT_READ, 12'd2400, 32'd400));
        send_item(make_item(ACT_READ, 12'd4095, 32'd500, 1'b0, 1'b1));
        // A sample is ignored in direct mode, and action 3 is always ignored.
        send_item(make_item(ACT_SAMPLE, 12'd4095, 32'hFFFF_FFFF));
        send_item(make_item(ACT_UNUSED, 12'd4095, 32'hFFFF_FFFF, 1'b1, 1'b1));
        send_item(make_item(ACT_READ, 12'd1, 32'd3100));
        send_item(make_item(ACT_REOPEN, 12'd0, 32'd0));
        send_item(make_item(ACT_READ, 12'd1200, 32'd5000));
        send_item(make_item(ACT_READ, 12'd1200, 32'd8000));
    endtask

    // Stream mode: the peak is taken and cleared by a read, a read with no
    // new samples repeats the held value, and a tuning read keeps the peak.
    task automatic test_stream_peak();
        settle();
        write_reg(CFG_STREAM_MODE, 16'd1);
        send_item(make_item(ACT_REOPEN, 12'd0, 32'd0));
        send_item(make_item(ACT_SAMPLE, 12'd5, 32'd0));
        send_item(make_item(ACT_SAMPLE, 12'd4095, 32'd0));
        send_item(make_item(ACT_SAMPLE, 12'd7, 32'd0));
        send_item(make_item(ACT_READ, 12'd0, 32'd10));
        send_item(make_item(ACT_READ, 12'd0, 32'd20));
        send_item(make_item(ACT_SAMPLE, 12'd100, 32'd0));
        send_item(make_item(ACT_READ, 12'd0, 32'd30, 1'b1));
        send_item(make_item(ACT_READ, 12'd0, 32'd40));
    endtask

    // Window end marks that wrap past the top of the time range, an end mark
    // of exactly zero, and a zero full scale.
    task automatic test_window_edges();
        settle();
        write_reg(CFG_WIN_LEN, 16'hFFFF);
        send_item(make_item(ACT_REOPEN, 12'd0, 32'd0));
        send_item(make_item(ACT_SAMPLE, 12'd9, 32'd0));
        send_item(make_item(ACT_READ, 12'd0, 32'hFFFF_FFF0));
        send_item(make_item(ACT_READ, 12'd0, 32'hFFFF_FFF5));
        settle();
        write_reg(CFG_WIN_LEN, 16'd16);
        write_reg(CFG_FS_STREAM, 16'hE000);
        send_item(make_item(ACT_REOPEN, 12'd0, 32'd0));
        send_item(make_item(ACT_READ, 12'd0, 32'hFFFF_FFF0));
        send_item(make_item(ACT_SAMPLE, 12'd4095, 32'd0));
        send_item(make_item(ACT_READ, 12'd0, 32'd0));
    endtask

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        int unsigned r;
        r = $urandom_range(0, 7);
        if (steady) return steady_val;
        if (r == 0) return '0;
        if (r == 1) return '1;
        return SAMPLE_BITS'($urandom());
    endfunction

    // Mostly well-formed traffic: reads with time moving forward so that
    // windows close, samples between reads in stream mode, and reopens once a
    // verdict is latched. The rest is noise: time jumps, ignored items.
    task automatic roll_item(output t_in_item it);
        int unsigned r;
        int unsigned reopen_pct;
        r = $urandom_range(0, 99);
        reopen_pct = m_done ? 20 : 4;
        it = make_item(ACT_SAMPLE, pick_sample(), TIME_BITS'($urandom()),
                       ($urandom_range(0, 9) == 0), ($urandom_range(0, 6) == 0));
        if (r < (m_stream ? 45 : 8)) begin
            it.action = ACT_SAMPLE;
        end else if (r < 96 - reopen_pct) begin
            it.action = ACT_READ;
            r = $urandom_range(0, 59);
            if (r == 0) wall_ms = TIME_BITS'($urandom());
            else if (r == 1) wall_ms = '1 - TIME_BITS'($urandom_range(0, m_win_len));
            else wall_ms = wall_ms + TIME_BITS'($urandom_range(0, m_win_len / 2 + 2));
            it.now_ms = wall_ms;
        end else if (r < 96) begin
            it.action = ACT_REOPEN;
            steady = ($urandom_range(0, 2) == 0);
            steady_val = SAMPLE_BITS'($urandom());
        end else begin
            it.action = ACT_UNUSED;
        end
    endtask

    // Sends bursts of random length with gaps of random length between them.
    // Ignored items do not count toward the phase length.
    task automatic run_phase(input int unsigned n_items, input bit hold_off);
        int unsigned counted;
        int unsigned burst;
        int unsigned r;
        bit          held;
        t_in_item    it;
        counted = 0;
        held = 1'b0;
        while (counted < n_items) begin
            burst = $urandom_range(1, 16);
            repeat (burst) begin
                roll_item(it);
                send_item(it);
                if (!(it.action == ACT_UNUSED || (it.action == ACT_SAMPLE && !m_stream)))
                    counted++;
            end
            r = $urandom_range(0, 9);
            if (hold_off && !held && counted >= n_items / 2) begin
                // Let the block run dry before going on.
                wait_reports();
                held = 1'b1;
            end else if (r < 4) begin
                pause_sender(0);
            end else if (r < 8) begin
                pause_sender($urandom_range(1, 4));
            end else if (r == 8) begin
                pause_sender($urandom_range(5, 13));
            end else begin
                pause_sender($urandom_range(20, 40));
            end
        end
    endtask

    task automatic test_random_phases();
        set_registers(1'b0, 13'd1, 13'd8191, 16'd1);
        run_phase(PHASE_ITEMS, 1'b0);
        set_registers(1'b1, SCALE_BITS'($urandom_range(1, 8191)), 13'd8191, 16'hFFFF);
        run_phase(PHASE_ITEMS, 1'b0);
        set_registers(1'b0, 13'd8191, 13'd1, WLEN_BITS'($urandom_range(1, 2000)));
        run_phase(PHASE_ITEMS, 1'b1);
        set_registers(1'b1, 13'd2400, 13'd0, 16'd3000);
        run_phase(PHASE_ITEMS, 1'b0);
        set_registers(1'b0, SCALE_BITS'($urandom_range(1, 4095)),
                      SCALE_BITS'($urandom_range(1, 4095)), WLEN_BITS'($urandom()));
        run_phase(PHASE_ITEMS, 1'b0);
        set_registers(1'b1, 13'd0, SCALE_BITS'($urandom_range(1, 4095)), 16'd1);
        run_phase(PHASE_ITEMS, 1'b0);
    endtask

    // The receiver's habit follows the top bits of rx_tick: always ready, coin
    // flip, mostly stalled, and a fixed duty cycle with a long stall.
    logic [9:0] rx_tick = '0;

    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 10'd1;
        case (rx_tick[9:8])
            2'd0:    i_ready <= 1'b1;
            2'd1:    i_ready <= 1'($urandom_range(0, 1));
            2'd2:    i_ready <= ($urandom_range(0, 7) == 0);
            default: i_ready <= (rx_tick[4:0] < 5'd18);
        endcase
    end

    task automatic check_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid && i_ready) begin
            if (reports_due.size() == 0) begin
                errors++;
                $display("%0t: report with none due, expected nothing, actual %h",
                         $time, o_data);
            end else begin
                want = reports_due.pop_front();
                check_field("rssi_level", 16'(want.rssi_level), 16'(o_data.rssi_level));
                check_field("raw_used", 16'(want.raw_used), 16'(o_data.raw_used));
                check_field("check_done", 16'(want.check_done), 16'(o_data.check_done));
                check_field("input_flat", 16'(want.input_flat), 16'(o_data.input_flat));
            end
        end
    end

    // Hang detection: any handshake on either channel resets the count.
    int unsigned quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= HANG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
            $display("[rssi_peak_scale_liveness] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        reset_model();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_direct_reads();
        test_stream_peak();
        test_window_edges();
        test_random_phases();
        // Every report must be in, and nothing may trail after the last one.
        settle();
        if (errors == 0 && reports_due.size() == 0) begin
            $display("[rssi_peak_scale_liveness] OK");
        end else begin
            $display("[rssi_peak_scale_liveness] ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/rpsl_pkg.sv
rtl/core/rssi_peak_scale_liveness.sv
rtl/core/rpsl_checker.sv
bench/tb_top.sv
